/* rtl/pbt_pkg.sv */
// ----------------------------------------------------------------------------
// pbt_pkg
// Shared types and constants for the playback time base.
// ----------------------------------------------------------------------------
package pbt_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int RATE_W        = 16;
	localparam int DUR_W         = 31;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOOP_DURATION  = 3'd0,
		CFG_PLAY_MODE      = 3'd1,
		CFG_PLAY_BACKWARD  = 3'd2,
		CFG_RATE_MAGNITUDE = 3'd3,
		CFG_RATE_NEGATIVE  = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_STOP     = 2'd0,
		MODE_LOOP     = 2'd1,
		MODE_PING     = 2'd2,
		MODE_PINGPONG = 2'd3
	} mode_t;

	localparam logic CMD_ADVANCE = 1'b0;
	localparam logic CMD_SET     = 1'b1;

	typedef struct packed {
		logic              command;
		logic              paused;
		logic signed [31:0] time_value;
	} in_t;

	typedef struct packed {
		logic        finished;
		logic [31:0] mapped_time;
		logic        forward;
	} out_t;

endpackage

/* rtl/pbt_div.sv */
// ----------------------------------------------------------------------------
// pbt_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pbt_div #(
	parameter int DW = 40,
	parameter int VW = 33
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quo,
	output logic [VW-1:0] rem
);
	localparam int CW = $clog2(DW);

	logic [VW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   sh;
	logic [VW:0]   diff;

	assign sh   = {rem_q, quo_q[DW-1]};
	assign diff = sh - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!diff[VW]) begin
				rem_q <= diff[VW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= sh[VW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

/* rtl/pbt_mul.sv */
// ----------------------------------------------------------------------------
// pbt_mul
// Iterative shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pbt_mul #(
	parameter int AW = 33,
	parameter int BW = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic             done,
	output logic [AW+BW-1:0] prod
);
	localparam int PW = AW + BW;
	localparam int CW = $clog2(BW);

	logic [PW-1:0] a_q;
	logic [BW-1:0] b_q;
	logic [PW-1:0] acc_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(BW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= PW'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[PW-2:0], 1'b0};
			b_q <= {1'b0, b_q[BW-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

/* rtl/playback_time_base.sv */
// ----------------------------------------------------------------------------
// playback_time_base
// Maps global time onto local playback time with stop/loop/ping/ping-pong modes.
// An advance may use the 16-bit shift-add multiplier and up to two passes of the shared divider.
// Throughput: one transaction at a time; in_ready is low until the result is loaded.
// Reset: asynchronous, clears time state, marks the offset stale, loads register defaults.
// ----------------------------------------------------------------------------
module playback_time_base
	import pbt_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_t                  out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int LW = (TIME_BITS > 32) ? TIME_BITS : 32;
	localparam int OW = LW + 2;
	localparam int DW = LW + 8;
	localparam int VW = 33;
	localparam int AW = OW - 1;
	localparam int PW = AW + RATE_W;
	localparam int XW = LW + 2;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_RDIV = 9'b000000010,
		ST_MUL  = 9'b000000100,
		ST_WRAP = 9'b000001000,
		ST_ADIV = 9'b000010000,
		ST_SDIV = 9'b000100000,
		ST_VIEW = 9'b001000000,
		ST_VDIV = 9'b010000000,
		ST_DONE = 9'b100000000
	} state_t;

	state_t                state_q;
	logic [DUR_W-1:0]      dur_q;
	mode_t                 mode_q;
	logic                  back_q;
	logic [RATE_W-1:0]     rate_q;
	logic                  rneg_q;
	logic [LW-1:0]         lt_q;
	logic signed [OW-1:0]  off_q;
	logic                  stale_q;
	logic signed [31:0]    t_q;
	logic                  fin_q;
	logic                  neg_q;
	logic [31:0]           mod_q;
	logic [31:0]           mraw_q;
	logic                  out_valid_q;
	out_t                  out_q;

	logic                  div_go_q;
	logic [DW-1:0]         div_a_q;
	logic [VW-1:0]         div_b_q;
	logic                  div_done;
	logic [DW-1:0]         div_quo;
	logic [VW-1:0]         div_rem;
	logic                  mul_go_q;
	logic [AW-1:0]         mul_a_q;
	logic                  mul_done;
	logic [PW-1:0]         mul_prod;

	logic                  rev;
	logic [LW-1:0]         dur_l;
	logic [LW-1:0]         d2_l;
	logic [LW-1:0]         tmax_l;
	logic signed [31:0]    t_in;
	logic signed [33:0]    t34;
	logic signed [33:0]    tp;
	logic [33:0]           tabs;
	logic signed [OW-1:0]  s_sum;
	logic [LW-1:0]         q_sat;
	logic [PW-9:0]         p_sc;
	logic [31:0]           mapped;

	pbt_div #(.DW(DW), .VW(VW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go_q),
		.dividend (div_a_q),
		.divisor  (div_b_q),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	pbt_mul #(.AW(AW), .BW(RATE_W)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_go_q),
		.a      (mul_a_q),
		.b      (rate_q),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	assign rev    = back_q ^ rneg_q;
	assign dur_l  = LW'(dur_q);
	assign d2_l   = LW'({dur_q, 1'b0});
	assign tmax_l = LW'({TIME_BITS{1'b1}});
	assign t_in   = in_data.time_value;
	assign t34    = 34'(t_in);
	assign tp     = rev ? ($signed({3'b000, dur_q}) - t34) : t34;
	assign tabs   = tp[33] ? 34'(-tp) : 34'(tp);
	assign s_sum  = off_q + OW'(t_in);
	assign q_sat  = (div_quo > DW'(tmax_l)) ? tmax_l : LW'(div_quo);
	assign p_sc   = mul_prod[PW-1:8];
	assign mapped = rev ? ({1'b0, dur_q} - mraw_q) : mraw_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q  <= '0;
			mode_q <= MODE_STOP;
			back_q <= 1'b0;
			rate_q <= RATE_W'(256);
			rneg_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_LOOP_DURATION:  dur_q  <= cfg_data[DUR_W-1:0];
				CFG_PLAY_MODE:      mode_q <= mode_t'(cfg_data[1:0]);
				CFG_PLAY_BACKWARD:  back_q <= cfg_data[0];
				CFG_RATE_MAGNITUDE: rate_q <= cfg_data[RATE_W-1:0];
				CFG_RATE_NEGATIVE:  rneg_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lt_q        <= '0;
			off_q       <= '0;
			stale_q     <= 1'b1;
			out_valid_q <= 1'b0;
			div_go_q    <= 1'b0;
			mul_go_q    <= 1'b0;
			fin_q       <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			mul_go_q <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						t_q   <= t_in;
						fin_q <= 1'b0;
						if (in_data.command == CMD_ADVANCE) begin
							if (in_data.paused || stale_q) begin
								stale_q <= 1'b0;
								if (rate_q != '0) begin
									div_a_q  <= DW'({lt_q, 8'h00});
									div_b_q  <= VW'(rate_q);
									div_go_q <= 1'b1;
									state_q  <= ST_RDIV;
								end else begin
									off_q   <= $signed({2'b00, lt_q}) - OW'(t_in);
									state_q <= ST_VIEW;
								end
							end else if (rate_q != '0) begin
								mul_a_q  <= s_sum[OW-1] ? '0 : s_sum[AW-1:0];
								mul_go_q <= 1'b1;
								state_q  <= ST_MUL;
							end else begin
								state_q <= ST_WRAP;
							end
						end else begin
							stale_q <= 1'b1;
							neg_q   <= tp[33];
							state_q <= ST_VIEW;
							if (dur_q == '0) begin
								if (tp[33]) begin
									lt_q <= '0;
								end else if (XW'(tp[32:0]) > XW'(tmax_l)) begin
									lt_q <= tmax_l;
								end else begin
									lt_q <= LW'(tp[32:0]);
								end
							end else begin
								case (mode_q)
									MODE_STOP: begin
										if (tp[33]) begin
											lt_q <= '0;
										end else if (tp > $signed({3'b000, dur_q})) begin
											lt_q <= dur_l;
										end else begin
											lt_q <= LW'(tp[31:0]);
										end
									end
									MODE_PING: begin
										if (tp[33]) begin
											lt_q <= '0;
										end else if (tp > $signed({2'b00, dur_q, 1'b0})) begin
											lt_q <= d2_l;
										end else begin
											lt_q <= LW'(tp[31:0]);
										end
									end
									default: begin
										mod_q    <= (mode_q == MODE_LOOP) ? {1'b0, dur_q}
										                               : {dur_q, 1'b0};
										div_a_q  <= DW'(tabs);
										div_b_q  <= (mode_q == MODE_LOOP) ? VW'(dur_q)
										                               : VW'({dur_q, 1'b0});
										div_go_q <= 1'b1;
										state_q  <= ST_SDIV;
									end
								endcase
							end
						end
					end
				end
				ST_RDIV: begin
					if (div_done) begin
						off_q   <= $signed({2'b00, q_sat}) - OW'(t_q);
						state_q <= ST_VIEW;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						lt_q    <= (p_sc > (PW-8)'(tmax_l)) ? tmax_l : LW'(p_sc);
						state_q <= ST_WRAP;
					end
				end
				ST_WRAP: begin
					state_q <= ST_VIEW;
					if (dur_q != '0) begin
						case (mode_q)
							MODE_STOP: begin
								if (lt_q > dur_l) begin
									fin_q <= 1'b1;
									lt_q  <= dur_l;
								end
							end
							MODE_PING: begin
								if (lt_q > d2_l) begin
									fin_q <= 1'b1;
									lt_q  <= d2_l;
								end
							end
							default: begin
								div_a_q  <= DW'(lt_q);
								div_b_q  <= (mode_q == MODE_LOOP) ? VW'(dur_q)
								                               : VW'({dur_q, 1'b0});
								div_go_q <= 1'b1;
								state_q  <= ST_ADIV;
							end
						endcase
					end
				end
				ST_ADIV: begin
					if (div_done) begin
						lt_q    <= LW'(div_rem);
						state_q <= ST_VIEW;
					end
				end
				ST_SDIV: begin
					if (div_done) begin
						if (neg_q && (div_rem != '0)) begin
							lt_q <= LW'(mod_q - div_rem[31:0]);
						end else begin
							lt_q <= LW'(div_rem);
						end
						state_q <= ST_VIEW;
					end
				end
				ST_VIEW: begin
					if ((dur_q != '0) && (lt_q >= dur_l)) begin
						div_a_q  <= DW'(lt_q);
						div_b_q  <= VW'(dur_q);
						div_go_q <= 1'b1;
						state_q  <= ST_VDIV;
					end else begin
						mraw_q  <= lt_q[31:0];
						state_q <= ST_DONE;
					end
				end
				ST_VDIV: begin
					if (div_done) begin
						case (mode_q)
							MODE_STOP: mraw_q <= {1'b0, dur_q};
							MODE_LOOP: mraw_q <= div_rem[31:0];
							MODE_PING: mraw_q <= (div_quo == DW'(1))
							                     ? ({1'b0, dur_q} - div_rem[31:0]) : '0;
							default:   mraw_q <= div_quo[0]
							                     ? ({1'b0, dur_q} - div_rem[31:0])
							                     : div_rem[31:0];
						endcase
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q       <= 1'b1;
						out_q.finished    <= fin_q;
						out_q.mapped_time <= mapped;
						out_q.forward     <= (lt_q < dur_l) ^ rev;
						state_q           <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/pbt_checker.sv */
// ----------------------------------------------------------------------------
// pbt_checker
// Port-level checks for the playback time base, bound to the top level.
// ----------------------------------------------------------------------------
module pbt_checker
	import pbt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data,
	input logic cfg_ready
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready stayed high after an input transaction");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a transaction in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled output transaction changed");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind playback_time_base pbt_checker u_pbt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.cfg_ready (cfg_ready)
);
